// ===== rtl/core/triangle_point_to_local_coords_core_macros.svh =====
// Assertion macros for the triangle local coordinate core.
`ifndef TRIANGLE_POINT_TO_LOCAL_COORDS_CORE_MACROS_SVH
`define TRIANGLE_POINT_TO_LOCAL_COORDS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TPLC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("tplc assertion failed");
`define TPLC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tplc assertion failed");
`else
`define TPLC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TPLC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/tplc_pkg.sv =====
// Shared types and constants for the triangle local coordinate core.
package tplc_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int MINOR_W = PROD_W + 1;

   localparam logic [1:0] PLANE_XY = 2'd0;
   localparam logic [1:0] PLANE_XZ = 2'd1;
   localparam logic [1:0] PLANE_YZ = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type vertex0_x;
      coord_type vertex0_y;
      coord_type vertex0_z;
      coord_type vertex1_x;
      coord_type vertex1_y;
      coord_type vertex1_z;
      coord_type vertex2_x;
      coord_type vertex2_y;
      coord_type vertex2_z;
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
   } req_word_type;

   typedef struct packed {
      coord_type  local_u;
      coord_type  local_v;
      logic [1:0] chosen_plane;
      logic       degenerate;
      logic       saturated;
   } rsp_word_type;

   // sideband that rides along the divider chain
   typedef struct packed {
      logic             valid;
      logic             degenerate;
      logic [1:0]       plane;
      logic             neg_u;
      logic             neg_v;
      logic [COORD_W:0] quo_u;
      logic [COORD_W:0] quo_v;
   } side_type;

endpackage

// ===== rtl/core/triangle_point_to_local_coords_core.sv =====
// Throughput: one word per cycle; busy stays low, so start may be held high.
// Depth is set by the divider chain: one cell per quotient bit plus an overflow cell.
// Reset (synchronous, active high) clears every valid bit; words in flight are dropped.
// rsp_valid is a one-cycle strobe; the receiver cannot stall the pipe.
// Top level: triangle point to local (u, v) coordinates.
`include "triangle_point_to_local_coords_core_macros.svh"
module triangle_point_to_local_coords_core import tplc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_data
);
   localparam int RW    = MINOR_W + COORD_W + FRAC_BITS;
   localparam int NCELL = COORD_W + 1;
   localparam int LAT   = COORD_W + 8;

   // chain taps: index 0 is the front end output, NCELL the last cell
   side_type           side_c [NCELL+1];
   logic [RW-1:0]      remu_c [NCELL+1];
   logic [RW-1:0]      remv_c [NCELL+1];
   logic [MINOR_W-1:0] den_c  [NCELL+1];

   side_type           last;
   logic               sat_u, sat_v;
   coord_type          val_u, val_v;
   rsp_word_type       rsp_in, rsp_ff;
   logic               valid_ff;

   // never stalls
   assign busy = 1'b0;

   tplc_minor #(.FRAC_BITS(FRAC_BITS)) u_minor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .req_data  (req_data),
      .side_out  (side_c[0]),
      .num_u_out (remu_c[0]),
      .num_v_out (remv_c[0]),
      .den_out   (den_c[0])
   );

   // first cell tests den << COORD_W: a set bit there means the quotient overflows
   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      tplc_cell #(.FRAC_BITS(FRAC_BITS), .SHIFT(COORD_W - i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_side  (side_c[i]),
         .up_rem_u (remu_c[i]),
         .up_rem_v (remv_c[i]),
         .up_den   (den_c[i]),
         .dn_side  (side_c[i+1]),
         .dn_rem_u (remu_c[i+1]),
         .dn_rem_v (remv_c[i+1]),
         .dn_den   (den_c[i+1])
      );
   end

   // sign restore and clip to the coordinate range
   always_comb begin
      last = side_c[NCELL];
      if (last.neg_u) begin
         sat_u = last.quo_u[COORD_W] |
                 (last.quo_u[COORD_W-1] & (|last.quo_u[COORD_W-2:0]));
         val_u = sat_u ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(-last.quo_u[COORD_W-1:0]);
      end else begin
         sat_u = last.quo_u[COORD_W] | last.quo_u[COORD_W-1];
         val_u = sat_u ? {1'b0, {(COORD_W-1){1'b1}}} : last.quo_u[COORD_W-1:0];
      end
      if (last.neg_v) begin
         sat_v = last.quo_v[COORD_W] |
                 (last.quo_v[COORD_W-1] & (|last.quo_v[COORD_W-2:0]));
         val_v = sat_v ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(-last.quo_v[COORD_W-1:0]);
      end else begin
         sat_v = last.quo_v[COORD_W] | last.quo_v[COORD_W-1];
         val_v = sat_v ? {1'b0, {(COORD_W-1){1'b1}}} : last.quo_v[COORD_W-1:0];
      end
      rsp_in.chosen_plane = last.plane;
      rsp_in.degenerate   = last.degenerate;
      if (last.degenerate) begin
         // flat triangle: all minors zero
         rsp_in.local_u   = '0;
         rsp_in.local_v   = '0;
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.local_u   = val_u;
         rsp_in.local_v   = val_v;
         rsp_in.saturated = sat_u | sat_v;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

   `TPLC_ASSERT_IMP(a_latency, clock, reset, start && !busy, ##LAT rsp_valid)
   `TPLC_ASSERT_NXT(a_degen_zero, clock, reset, last.valid && last.degenerate, rsp_data.local_u == '0 && rsp_data.local_v == '0 && !rsp_data.saturated && rsp_data.chosen_plane == PLANE_YZ)
   `TPLC_ASSERT_IMP(a_sat_rail, clock, reset, rsp_valid && rsp_data.saturated, (rsp_data.local_u == {1'b1, {(COORD_W-1){1'b0}}} || rsp_data.local_u == {1'b0, {(COORD_W-1){1'b1}}} || rsp_data.local_v == {1'b1, {(COORD_W-1){1'b0}}} || rsp_data.local_v == {1'b0, {(COORD_W-1){1'b1}}}))

endmodule

// ===== rtl/core/tplc_minor.sv =====
// Front end: edge vectors, Jacobian minors, plane pick and numerators.
module tplc_minor import tplc_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  req_word_type                           req_data,
   output side_type                               side_out,
   output logic [MINOR_W+COORD_W+FRAC_BITS-1:0]  num_u_out,
   output logic [MINOR_W+COORD_W+FRAC_BITS-1:0]  num_v_out,
   output logic [MINOR_W-1:0]                     den_out
);
   localparam int RW = MINOR_W + COORD_W + FRAC_BITS;

   // stage 1: differences from vertex 0
   logic signed [DIFF_W-1:0] e1_in [3], e2_in [3], d_in [3];
   logic signed [DIFF_W-1:0] e1_ff [3], e2_ff [3], d_ff [3];
   logic                     v1_ff;
   // stage 2: minor products
   logic signed [PROD_W-1:0] pa_in [3], pb_in [3], pa_ff [3], pb_ff [3];
   logic signed [DIFF_W-1:0] e1b_ff [3], e2b_ff [3], db_ff [3];
   logic                     v2_ff;
   // stage 3: minors
   logic signed [MINOR_W-1:0] j_in [3], j_ff [3];
   logic signed [DIFF_W-1:0]  e1c_ff [3], e2c_ff [3], dc_ff [3];
   logic                      v3_ff;
   // stage 4: plane pick
   logic [MINOR_W-1:0]        mag [3];
   logic                      xy_win, xz_win;
   logic [1:0]                plane_in, plane4_ff;
   logic [1:0]                pi, qi;
   logic signed [DIFF_W-1:0]  op_in [6], op_ff [6];
   logic signed [MINOR_W-1:0] jsel;
   logic [MINOR_W-1:0]        den4_ff;
   logic                      dsg4_ff, deg4_ff, v4_ff;
   // stage 5: numerator products
   logic signed [PROD_W-1:0]  np_in [4], np_ff [4];
   logic [MINOR_W-1:0]        den5_ff;
   logic [1:0]                plane5_ff;
   logic                      dsg5_ff, deg5_ff, v5_ff;
   // stage 6: numerator magnitudes
   logic signed [MINOR_W-1:0] nu, nv;
   logic [MINOR_W-1:0]        nu_mag, nv_mag;
   side_type                  side_in, side_ff;
   logic [RW-1:0]             numu_ff, numv_ff;
   logic [MINOR_W-1:0]        den6_ff;

   always_comb begin
      e1_in[0] = DIFF_W'(req_data.vertex1_x) - DIFF_W'(req_data.vertex0_x);
      e1_in[1] = DIFF_W'(req_data.vertex1_y) - DIFF_W'(req_data.vertex0_y);
      e1_in[2] = DIFF_W'(req_data.vertex1_z) - DIFF_W'(req_data.vertex0_z);
      e2_in[0] = DIFF_W'(req_data.vertex2_x) - DIFF_W'(req_data.vertex0_x);
      e2_in[1] = DIFF_W'(req_data.vertex2_y) - DIFF_W'(req_data.vertex0_y);
      e2_in[2] = DIFF_W'(req_data.vertex2_z) - DIFF_W'(req_data.vertex0_z);
      d_in[0]  = DIFF_W'(req_data.point_x) - DIFF_W'(req_data.vertex0_x);
      d_in[1]  = DIFF_W'(req_data.point_y) - DIFF_W'(req_data.vertex0_y);
      d_in[2]  = DIFF_W'(req_data.point_z) - DIFF_W'(req_data.vertex0_z);
   end

   // minors xy, xz, yz
   always_comb begin
      pa_in[0] = e1_ff[0] * e2_ff[1];
      pb_in[0] = e1_ff[1] * e2_ff[0];
      pa_in[1] = e1_ff[0] * e2_ff[2];
      pb_in[1] = e1_ff[2] * e2_ff[0];
      pa_in[2] = e1_ff[1] * e2_ff[2];
      pb_in[2] = e1_ff[2] * e2_ff[1];
      for (int k = 0; k < 3; k++) begin
         j_in[k] = MINOR_W'(pa_ff[k]) - MINOR_W'(pb_ff[k]);
      end
   end

   // strict compares, ties go to the later plane
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k] = j_ff[k][MINOR_W-1] ? MINOR_W'(-j_ff[k]) : MINOR_W'(j_ff[k]);
      end
      xy_win = (mag[0] > mag[1]) && (mag[0] > mag[2]);
      xz_win = (mag[1] > mag[2]);
      priority if (xy_win) begin
         plane_in = PLANE_XY;
         pi = 2'd0;
         qi = 2'd1;
         jsel = j_ff[0];
      end else if (xz_win) begin
         plane_in = PLANE_XZ;
         pi = 2'd0;
         qi = 2'd2;
         jsel = j_ff[1];
      end else begin
         plane_in = PLANE_YZ;
         pi = 2'd1;
         qi = 2'd2;
         jsel = j_ff[2];
      end
      op_in[0] = dc_ff[pi];
      op_in[1] = dc_ff[qi];
      op_in[2] = e1c_ff[pi];
      op_in[3] = e1c_ff[qi];
      op_in[4] = e2c_ff[pi];
      op_in[5] = e2c_ff[qi];
   end

   // nu = dp*e2q - dq*e2p, nv = dq*e1p - dp*e1q
   always_comb begin
      np_in[0] = op_ff[0] * op_ff[5];
      np_in[1] = op_ff[1] * op_ff[4];
      np_in[2] = op_ff[1] * op_ff[2];
      np_in[3] = op_ff[0] * op_ff[3];
   end

   always_comb begin
      nu = MINOR_W'(np_ff[0]) - MINOR_W'(np_ff[1]);
      nv = MINOR_W'(np_ff[2]) - MINOR_W'(np_ff[3]);
      nu_mag = nu[MINOR_W-1] ? MINOR_W'(-nu) : MINOR_W'(nu);
      nv_mag = nv[MINOR_W-1] ? MINOR_W'(-nv) : MINOR_W'(nv);
      side_in.valid      = v5_ff & ~reset;
      side_in.degenerate = deg5_ff;
      side_in.plane      = plane5_ff;
      side_in.neg_u      = nu[MINOR_W-1] ^ dsg5_ff;
      side_in.neg_v      = nv[MINOR_W-1] ^ dsg5_ff;
      side_in.quo_u      = '0;
      side_in.quo_v      = '0;
   end

   always_ff @(posedge clock) begin
      e1_ff  <= e1_in;
      e2_ff  <= e2_in;
      d_ff   <= d_in;
      pa_ff  <= pa_in;
      pb_ff  <= pb_in;
      e1b_ff <= e1_ff;
      e2b_ff <= e2_ff;
      db_ff  <= d_ff;
      j_ff   <= j_in;
      e1c_ff <= e1b_ff;
      e2c_ff <= e2b_ff;
      dc_ff  <= db_ff;
      op_ff     <= op_in;
      plane4_ff <= plane_in;
      den4_ff   <= jsel[MINOR_W-1] ? MINOR_W'(-jsel) : MINOR_W'(jsel);
      dsg4_ff   <= jsel[MINOR_W-1];
      deg4_ff   <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
      np_ff     <= np_in;
      den5_ff   <= den4_ff;
      plane5_ff <= plane4_ff;
      dsg5_ff   <= dsg4_ff;
      deg5_ff   <= deg4_ff;
      side_ff   <= side_in;
      numu_ff   <= RW'(nu_mag) << FRAC_BITS;
      numv_ff   <= RW'(nv_mag) << FRAC_BITS;
      den6_ff   <= den5_ff;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // v4_ff feeds stage 5 valid; v3_ff feeds stage 4
   assign side_out  = side_ff;
   assign num_u_out = numu_ff;
   assign num_v_out = numv_ff;
   assign den_out   = den6_ff;

endmodule

// ===== rtl/core/tplc_cell.sv =====
// One restoring-division cell: one quotient bit of u and of v per cycle.
module tplc_cell import tplc_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int SHIFT     = 0
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  side_type                               up_side,
   input  logic [MINOR_W+COORD_W+FRAC_BITS-1:0]  up_rem_u,
   input  logic [MINOR_W+COORD_W+FRAC_BITS-1:0]  up_rem_v,
   input  logic [MINOR_W-1:0]                     up_den,
   output side_type                               dn_side,
   output logic [MINOR_W+COORD_W+FRAC_BITS-1:0]  dn_rem_u,
   output logic [MINOR_W+COORD_W+FRAC_BITS-1:0]  dn_rem_v,
   output logic [MINOR_W-1:0]                     dn_den
);
   localparam int RW = MINOR_W + COORD_W + FRAC_BITS;

   logic [RW-1:0]      dsh;
   logic               ge_u, ge_v;
   side_type           side_in, side_ff;
   logic [RW-1:0]      remu_in, remv_in, remu_ff, remv_ff;
   logic [MINOR_W-1:0] den_ff;

   always_comb begin
      dsh     = RW'(up_den) << SHIFT;
      ge_u    = up_rem_u >= dsh;
      ge_v    = up_rem_v >= dsh;
      remu_in = ge_u ? up_rem_u - dsh : up_rem_u;
      remv_in = ge_v ? up_rem_v - dsh : up_rem_v;
      side_in = up_side;
      side_in.valid = up_side.valid & ~reset;
      side_in.quo_u = {up_side.quo_u[COORD_W-1:0], ge_u};
      side_in.quo_v = {up_side.quo_v[COORD_W-1:0], ge_v};
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      remu_ff <= remu_in;
      remv_ff <= remv_in;
      den_ff  <= up_den;
   end

   assign dn_side  = side_ff;
   assign dn_rem_u = remu_ff;
   assign dn_rem_v = remv_ff;
   assign dn_den   = den_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the triangle point to local coordinate core.
`timescale 1ns / 100ps
module tb;
   import tplc_pkg::*;

   // ports
   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_data;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   // expected results, oldest first
   rsp_word_type uv_expected_q[$];
   int           fail_count;
   int           words_sent;

   localparam int LATENCY = COORD_W + 8;
   localparam int FRAC    = 16;

   triangle_point_to_local_coords_core #(.FRAC_BITS(FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit: 872 words with their random gaps plus drain fit within it many times over.
   initial begin
      #5_000_000;
      $display("triangle_point_to_local_coords_core verification failed");
      $finish;
   end

   // Truncated quotient of num*2^FRAC/den, clipped to the coordinate range.
   function automatic logic signed [COORD_W-1:0] div_clip(
      input logic signed [MINOR_W-1:0] num,
      input logic signed [MINOR_W-1:0] den,
      inout logic                      clipped
   );
      logic [MINOR_W+FRAC-1:0] mag_n;
      logic [MINOR_W-1:0]      mag_d;
      logic [MINOR_W+FRAC-1:0] quo;
      logic                    neg;
      logic [COORD_W:0]        lim;
      neg   = num[MINOR_W-1] ^ den[MINOR_W-1];
      mag_n = (num < 0) ? {{FRAC{1'b0}}, -num} : {{FRAC{1'b0}}, num};
      mag_n = mag_n << FRAC;
      mag_d = (den < 0) ? -den : den;
      quo   = mag_n / mag_d;
      lim   = {1'b1, {COORD_W{1'b0}}} >> 1;
      if (neg) begin
         if (quo > lim) begin
            clipped = 1'b1;
            return lim[COORD_W-1:0];
         end
         return -quo[COORD_W-1:0];
      end
      if (quo > lim - 1) begin
         clipped = 1'b1;
         return lim[COORD_W-1:0] - 1;
      end
      return quo[COORD_W-1:0];
   endfunction

   function automatic logic signed [MINOR_W-1:0] cross2(
      input logic signed [DIFF_W:0] a, input logic signed [DIFF_W:0] b,
      input logic signed [DIFF_W:0] c, input logic signed [DIFF_W:0] d
   );
      logic signed [MINOR_W-1:0] p, q;
      p = MINOR_W'(a) * MINOR_W'(b);
      q = MINOR_W'(c) * MINOR_W'(d);
      return p - q;
   endfunction

   function automatic rsp_word_type map_to_local(input req_word_type w);
      logic signed [DIFF_W:0]    e1[3], e2[3], dp[3];
      logic signed [MINOR_W-1:0] jxy, jxz, jyz, axy, axz, ayz, jsel, nu, nv;
      int                        p, q;
      logic                      clipped;
      rsp_word_type              r;
      e1[0] = w.vertex1_x - w.vertex0_x;  e2[0] = w.vertex2_x - w.vertex0_x;
      e1[1] = w.vertex1_y - w.vertex0_y;  e2[1] = w.vertex2_y - w.vertex0_y;
      e1[2] = w.vertex1_z - w.vertex0_z;  e2[2] = w.vertex2_z - w.vertex0_z;
      dp[0] = w.point_x - w.vertex0_x;
      dp[1] = w.point_y - w.vertex0_y;
      dp[2] = w.point_z - w.vertex0_z;
      jxy = cross2(e1[0], e2[1], e1[1], e2[0]);
      jxz = cross2(e1[0], e2[2], e1[2], e2[0]);
      jyz = cross2(e1[1], e2[2], e1[2], e2[1]);
      axy = (jxy < 0) ? -jxy : jxy;
      axz = (jxz < 0) ? -jxz : jxz;
      ayz = (jyz < 0) ? -jyz : jyz;
      r = '0;
      // strict compares: ties go to the later plane
      if (axy > axz && axy > ayz) begin
         r.chosen_plane = PLANE_XY; p = 0; q = 1; jsel = jxy;
      end else if (axz > ayz) begin
         r.chosen_plane = PLANE_XZ; p = 0; q = 2; jsel = jxz;
      end else begin
         r.chosen_plane = PLANE_YZ; p = 1; q = 2; jsel = jyz;
      end
      if (jxy == 0 && jxz == 0 && jyz == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      clipped   = 1'b0;
      nu        = cross2(dp[p], e2[q], dp[q], e2[p]);
      nv        = cross2(dp[q], e1[p], dp[p], e1[q]);
      r.local_u = div_clip(nu, jsel, clipped);
      r.local_v = div_clip(nv, jsel, clipped);
      r.saturated = clipped;
      return r;
   endfunction

   // Drive one word after a random gap unless no_gap is set; accepted at the next edge with busy low.
   task automatic send_word(input req_word_type w, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(14);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      uv_expected_q.push_back(map_to_local(w));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (uv_expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic coord_type rand_coord(input int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(2 << FRAC)) - (1 << FRAC));
         2: return coord_type'($signed($urandom_range(2000)) - 1000);
         default: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      endcase
   endfunction

   function automatic req_word_type rand_word(input int mode);
      req_word_type w;
      w.vertex0_x = rand_coord(mode); w.vertex0_y = rand_coord(mode);
      w.vertex0_z = rand_coord(mode); w.vertex1_x = rand_coord(mode);
      w.vertex1_y = rand_coord(mode); w.vertex1_z = rand_coord(mode);
      w.vertex2_x = rand_coord(mode); w.vertex2_y = rand_coord(mode);
      w.vertex2_z = rand_coord(mode); w.point_x   = rand_coord(mode);
      w.point_y   = rand_coord(mode); w.point_z   = rand_coord(mode);
      return w;
   endfunction

   // directed: extremes, each plane, ties, degenerate, saturation, negative minor
   task automatic test_directed();
      req_word_type w;
      localparam coord_type ONE = 1 << FRAC;
      localparam coord_type MAXC = 32'sh7fffffff;
      localparam coord_type MINC = 32'sh80000000;
      w = '0;
      send_word(w);                                        // all zero: degenerate
      w = '1;
      send_word(w);                                        // all equal: degenerate
      w = '0; w.vertex1_x = ONE; w.vertex2_y = ONE;
      w.point_x = ONE / 4; w.point_y = ONE / 2;
      send_word(w);                                        // xy plane
      w = '0; w.vertex1_x = ONE; w.vertex2_z = ONE; w.point_z = ONE;
      send_word(w);                                        // xz plane
      w = '0; w.vertex1_y = ONE; w.vertex2_z = ONE; w.point_y = -ONE;
      send_word(w);                                        // yz plane
      w = '0; w.vertex1_x = ONE; w.vertex2_y = ONE; w.vertex2_z = ONE;
      send_word(w);                                        // xy/xz tie
      w = '0; w.vertex1_x = ONE; w.vertex1_y = ONE; w.vertex2_z = ONE;
      send_word(w);                                        // xz/yz tie
      w = '0; w.vertex1_x = ONE; w.vertex1_y = ONE; w.vertex1_z = ONE;
      w.vertex2_x = 2 * ONE; w.vertex2_y = 2 * ONE; w.vertex2_z = 2 * ONE;
      send_word(w);                                        // collinear: degenerate
      w = '0; w.vertex1_x = 1; w.vertex2_y = 1; w.point_x = MAXC; w.point_y = MINC;
      send_word(w);                                        // saturate both ways
      w = '0; w.vertex0_x = MINC; w.vertex0_y = MINC; w.vertex0_z = MINC;
      w.vertex1_x = MAXC; w.vertex2_y = MAXC; w.vertex2_z = MAXC;
      w.point_x = MAXC; w.point_y = MAXC; w.point_z = MINC;
      send_word(w);                                        // widest differences
      w = '0; w.vertex1_x = MINC; w.vertex2_y = MAXC; w.point_x = MAXC;
      w.point_y = MINC; w.vertex0_z = MAXC; w.point_z = MINC;
      send_word(w);
      for (int i = 0; i < 10; i++) send_word(rand_word(3));
      w = '0; w.vertex1_x = ONE; w.vertex2_y = -ONE; w.point_x = -ONE; w.point_y = ONE;
      send_word(w);                                        // negative minor
   endtask

   // random mix, with back-to-back bursts and one full drain in the middle
   task automatic test_random();
      int m;
      for (int i = 0; i < 850; i++) begin
         m = $urandom_range(9);
         if (i == 400) drain_results();
         send_word(rand_word(m < 4 ? 0 : m < 7 ? 1 : m < 9 ? 2 : 3),
                   (i % 100) < 20);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (uv_expected_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            e = uv_expected_q.pop_front();
            if (rsp_data.local_u !== e.local_u) begin
               $display("%0t: local_u expected %h actual %h", $time, e.local_u,
                        rsp_data.local_u);
               fail_count++;
            end
            if (rsp_data.local_v !== e.local_v) begin
               $display("%0t: local_v expected %h actual %h", $time, e.local_v,
                        rsp_data.local_v);
               fail_count++;
            end
            if (rsp_data.chosen_plane !== e.chosen_plane) begin
               $display("%0t: chosen_plane expected %0d actual %0d", $time,
                        e.chosen_plane, rsp_data.chosen_plane);
               fail_count++;
            end
            if (rsp_data.degenerate !== e.degenerate) begin
               $display("%0t: degenerate expected %b actual %b", $time, e.degenerate,
                        rsp_data.degenerate);
               fail_count++;
            end
            if (rsp_data.saturated !== e.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time, e.saturated,
                        rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      words_sent = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      drain_results();
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && uv_expected_q.size() == 0)
         $display("triangle_point_to_local_coords_core verification clean");
      else
         $display("triangle_point_to_local_coords_core verification failed");
      $finish;
   end
endmodule
